// ----- rtl/vfp_pkg.sv -----
// ----------------------------------------------------------------------------
// vfp_pkg
// Shared constants and types of the video frame packetizer.
// ----------------------------------------------------------------------------
package vfp_pkg;

   localparam int LENGTH_BITS    = 24;
   localparam int HDR_BYTES      = 17;
   localparam int MIN_PKT        = HDR_BYTES + 1;
   localparam int PKT_RESET_SIZE = 32 * 1024;
   localparam int JOB_BYTES      = HDR_BYTES + 1;
   localparam int JOB_BITS       = JOB_BYTES * 8;
   localparam int IDX_BITS       = $clog2(JOB_BYTES);

   localparam logic [31:0]           START_CODE = 32'h0000_01FC;
   localparam logic [7:0]            TYPE_CODE  = 8'h00;
   localparam logic [IDX_BITS-1:0]   IDX_FIRST  = '0;
   localparam logic [IDX_BITS-1:0]   IDX_DATA   = IDX_BITS'(HDR_BYTES);

   localparam int CSR_ADDR_BITS = 3;
   localparam logic IDX_MAX_PACKET = 1'b0;

   typedef struct packed {
      logic                emit;
      logic                hdr;
      logic                plast;
      logic                fdone;
      logic [JOB_BITS-1:0] bytes;
   } job_type;

endpackage

// ----- rtl/vfp_req_if.sv -----
// ----------------------------------------------------------------------------
// vfp_req_if
// Input channel: one encoded frame byte per item.
// ----------------------------------------------------------------------------
interface vfp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        frame_first;
   logic [23:0] frame_length;
   logic [31:0] timestamp_ms;

   modport source (
      output valid, data_byte, frame_first, frame_length, timestamp_ms,
      input  ready
   );
   modport sink (
      input  valid, data_byte, frame_first, frame_length, timestamp_ms,
      output ready
   );
endinterface

// ----- rtl/vfp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vfp_rsp_if
// Result channel: one packet byte with packet and frame end marks per item.
// ----------------------------------------------------------------------------
interface vfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_last;
   logic       frame_done;

   modport source (output valid, out_byte, packet_last, frame_done, input ready);
   modport sink   (input  valid, out_byte, packet_last, frame_done, output ready);
endinterface

// ----- rtl/vfp_framer.sv -----
// ----------------------------------------------------------------------------
// vfp_framer
// Frame and packet bookkeeping; turns one accepted byte into an output job.
// ----------------------------------------------------------------------------
module vfp_framer
   import vfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        frame_first,
   input  logic [23:0] frame_length,
   input  logic [31:0] timestamp_ms,
   input  logic [15:0] max_packet_bytes,
   output job_type     job
);

   logic [31:0]            counter_ff, counter_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [15:0]            pkt_ff, pkt_in;
   logic                   infirst_ff, infirst_in;

   logic [LENGTH_BITS-1:0] flen, left_base, left_next;
   logic [15:0]            pkt_base, pkt_next, maxp, cap;
   logic                   infirst_base, has_data;

   always_comb begin
      counter_in   = frame_first ? (counter_ff + 32'd1) : counter_ff;
      flen         = LENGTH_BITS'(frame_length);
      left_base    = frame_first ? flen : left_ff;
      pkt_base     = frame_first ? 16'd0 : pkt_ff;
      infirst_base = frame_first | infirst_ff;
      has_data     = (left_base != '0);
      left_next    = left_base - LENGTH_BITS'(1);
      pkt_next     = pkt_base + 16'd1;
      maxp         = (max_packet_bytes < 16'(MIN_PKT)) ? 16'(MIN_PKT) : max_packet_bytes;
      cap          = infirst_base ? (maxp - 16'(HDR_BYTES)) : maxp;

      job.emit  = has_data;
      job.hdr   = frame_first;
      job.fdone = (left_next == '0);
      job.plast = job.fdone | (pkt_next >= cap);
      if (frame_first) begin
         job.bytes = {START_CODE, 32'(flen), timestamp_ms, counter_in, TYPE_CODE, data_byte};
      end else begin
         job.bytes = {data_byte, (JOB_BITS - 8)'(0)};
      end

      left_in    = left_base;
      pkt_in     = pkt_base;
      infirst_in = infirst_base;
      if (has_data) begin
         left_in    = left_next;
         pkt_in     = job.plast ? 16'd0 : pkt_next;
         infirst_in = job.plast ? 1'b0 : infirst_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         left_ff    <= '0;
         pkt_ff     <= '0;
         infirst_ff <= 1'b0;
      end else if (accept) begin
         counter_ff <= counter_in;
         left_ff    <= left_in;
         pkt_ff     <= pkt_in;
         infirst_ff <= infirst_in;
      end
   end

endmodule

// ----- rtl/video_frame_packetizer.sv -----
// ----------------------------------------------------------------------------
// video_frame_packetizer
// Frame byte stream to packet byte stream with a 17-byte frame header.
// Timing: the first result byte is valid in the cycle after the item is accepted.
// Throughput: one data byte per cycle while rsp_chan is ready; a first byte
// sends the header burst from the output shift register; stray bytes emit none.
// Reset: synchronous; counters clear, max_packet_bytes returns to 32768.
// ----------------------------------------------------------------------------
module video_frame_packetizer
   import vfp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   vfp_req_if.sink                  req_chan,
   vfp_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [15:0]         max_ff;
   logic                busy_ff, busy_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [JOB_BITS-1:0] shift_ff, shift_in;
   logic                plast_ff, plast_in;
   logic                fdone_ff, fdone_in;

   logic    accept, out_take, at_data, csr_write;
   job_type job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite &
                       (csr_paddr[CSR_ADDR_BITS-1] == IDX_MAX_PACKET);
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == IDX_MAX_PACKET) ?
                       {16'd0, max_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 16'(PKT_RESET_SIZE);
      end else if (csr_write) begin
         max_ff <= csr_pwdata[15:0];
      end
   end

   assign at_data        = (idx_ff == IDX_DATA);
   assign out_take       = rsp_chan.valid & rsp_chan.ready;
   assign req_chan.ready = ~busy_ff | (out_take & at_data);
   assign accept         = req_chan.valid & req_chan.ready;

   vfp_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_chan.data_byte),
      .frame_first      (req_chan.frame_first),
      .frame_length     (req_chan.frame_length),
      .timestamp_ms     (req_chan.timestamp_ms),
      .max_packet_bytes (max_ff),
      .job              (job)
   );

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      plast_in = plast_ff;
      fdone_in = fdone_ff;
      if (accept & job.emit) begin
         busy_in  = 1'b1;
         idx_in   = job.hdr ? IDX_FIRST : IDX_DATA;
         shift_in = job.bytes;
         plast_in = job.plast;
         fdone_in = job.fdone;
      end else if (out_take) begin
         busy_in  = ~at_data;
         idx_in   = at_data ? idx_ff : (idx_ff + IDX_BITS'(1));
         shift_in = {shift_ff[JOB_BITS-9:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= IDX_FIRST;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      plast_ff <= plast_in;
      fdone_ff <= fdone_in;
   end

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.out_byte    = shift_ff[JOB_BITS-1 -: 8];
   assign rsp_chan.packet_last = plast_ff & at_data;
   assign rsp_chan.frame_done  = fdone_ff & at_data;

endmodule
